FILE: hdl/apm_pkg.sv
package apm_pkg;
  localparam int unsigned HistoryLenDefault  = 5;
  localparam int unsigned SampleBitsDefault  = 12;
  localparam int unsigned Channels           = 4;
  localparam int unsigned CfgIdxBits         = 3;
  localparam int unsigned CfgDataBits        = 20;
  localparam int unsigned TickBits           = 10;
  localparam int unsigned MedBits            = 12;
  localparam int unsigned PowBits            = 25;
  localparam logic [TickBits-1:0] TickTop    = 10'd1023;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_WEIGHT  = 3'd0,
    REG_WINDOW  = 3'd1,
    REG_VOFF1   = 3'd2,
    REG_VOFF2   = 3'd3,
    REG_AZERO   = 3'd4,
    REG_GAIN    = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SORT,
    BK_MUL,
    BK_OUT
  } bk_state_e;
endpackage

FILE: hdl/apm_front.sv
module apm_front #(
  parameter int unsigned HistoryLen = apm_pkg::HistoryLenDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [4*apm_pkg::SampleBitsDefault-1:0] in_data_i,
  input  logic [7:0]                   weight_i,
  input  logic [9:0]                   window_i,
  output logic                         job_valid_o,
  input  logic                         job_ready_i,
  output logic [4*HistoryLen*12-1:0]   job_hist_o
);
  import apm_pkg::*;

  localparam int unsigned SampleBits = SampleBitsDefault;
  localparam int unsigned LvlBits = SampleBits + 8;
  localparam int unsigned CntBits = $clog2(HistoryLen + 1);
  localparam int unsigned IdxBits = (HistoryLen > 1) ? $clog2(HistoryLen) : 1;

  logic [LvlBits-1:0] lvl_q [Channels];
  logic [LvlBits-1:0] peak_q [Channels];
  logic [TickBits-1:0] tick_q;
  logic [CntBits-1:0] cnt_q;
  logic [11:0] hist_q [Channels][HistoryLen];
  logic job_q;
  logic [LvlBits-1:0] lvl_d [Channels];
  logic close_w;
  logic acc_w;

  assign in_ready_o = !job_q;
  assign acc_w = in_valid_i && in_ready_o;
  assign close_w = (tick_q > window_i) || (tick_q >= TickTop);
  assign job_valid_o = job_q;

  always_comb begin
    for (int c = 0; c < Channels; c++) begin
      logic [LvlBits+8:0] s;
      s = (LvlBits+9)'(weight_i) * (LvlBits+9)'(lvl_q[c])
        + (LvlBits+9)'(9'd256 - 9'(weight_i))
          * (LvlBits+9)'({in_data_i[c*SampleBits +: SampleBits], 8'd0})
        + (LvlBits+9)'(128);
      lvl_d[c] = s[LvlBits+7:8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
      cnt_q  <= '0;
      job_q  <= 1'b0;
      for (int c = 0; c < Channels; c++) begin
        lvl_q[c]  <= '0;
        peak_q[c] <= '0;
      end
    end else begin
      if (job_q && job_ready_i) job_q <= 1'b0;
      if (acc_w) begin
        for (int c = 0; c < Channels; c++) begin
          lvl_q[c] <= lvl_d[c];
          peak_q[c] <= close_w ? '0 : ((lvl_d[c] > peak_q[c]) ? lvl_d[c] : peak_q[c]);
        end
        if (close_w) begin
          tick_q <= '0;
          if (cnt_q < CntBits'(HistoryLen)) begin
            cnt_q <= cnt_q + 1'b1;
          end else begin
            cnt_q <= '0;
            job_q <= 1'b1;
          end
        end else begin
          tick_q <= tick_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_w && close_w && cnt_q < CntBits'(HistoryLen)) begin
      for (int c = 0; c < Channels; c++) begin
        logic [LvlBits-1:0] pk;
        pk = (lvl_d[c] > peak_q[c]) ? lvl_d[c] : peak_q[c];
        hist_q[c][IdxBits'(cnt_q)] <= 12'(pk[LvlBits-1:8]);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < Channels; c++)
      for (int h = 0; h < HistoryLen; h++)
        job_hist_o[(c*HistoryLen+h)*12 +: 12] = hist_q[c][h];
  end
endmodule

FILE: hdl/apm_back.sv
module apm_back #(
  parameter int unsigned HistoryLen = apm_pkg::HistoryLenDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        job_valid_i,
  output logic                        job_ready_o,
  input  logic [4*HistoryLen*12-1:0]  job_hist_i,
  input  logic [11:0]                 voff1_i,
  input  logic [11:0]                 voff2_i,
  input  logic [11:0]                 azero_i,
  input  logic [19:0]                 gain_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [11:0]                 med_o [4],
  output logic signed [24:0]          pow_o [2]
);
  import apm_pkg::*;

  localparam int unsigned PassBits = $clog2(HistoryLen + 1);

  bk_state_e st_q, st_d;
  logic [11:0] buf_q [Channels][HistoryLen];
  logic [PassBits-1:0] pass_q;
  logic [23:0] prod_q [2];
  logic neg_q [2];
  logic [44:0] mag_w [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BK_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_comb begin
    st_d = st_q;
    job_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (st_q)
      BK_IDLE: begin
        job_ready_o = 1'b1;
        if (job_valid_i) st_d = BK_SORT;
      end
      BK_SORT: if (pass_q == PassBits'(HistoryLen - 1)) st_d = BK_MUL;
      BK_MUL: st_d = BK_OUT;
      BK_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) st_d = BK_IDLE;
      end
      default: st_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_q == BK_IDLE) begin
      pass_q <= '0;
      for (int c = 0; c < Channels; c++)
        for (int h = 0; h < HistoryLen; h++)
          buf_q[c][h] <= job_hist_i[(c*HistoryLen+h)*12 +: 12];
    end
    if (st_q == BK_SORT) begin
      pass_q <= pass_q + 1'b1;
      // odd-even transposition: alternate parity each pass
      for (int c = 0; c < Channels; c++)
        for (int h = 0; h + 1 < HistoryLen; h++)
          if ((h % 2) == int'(pass_q[0]) && buf_q[c][h] > buf_q[c][h+1]) begin
            buf_q[c][h]   <= buf_q[c][h+1];
            buf_q[c][h+1] <= buf_q[c][h];
          end
    end
    if (st_q == BK_MUL) begin
      for (int p = 0; p < 2; p++) begin
        logic [11:0] v, vo, a;
        v  = buf_q[p][HistoryLen/2];
        a  = buf_q[p+2][HistoryLen/2];
        vo = p == 0 ? voff1_i : voff2_i;
        prod_q[p] <= 24'((v >= vo ? v - vo : vo - v)) * 24'((a >= azero_i ? a - azero_i : azero_i - a));
        neg_q[p]  <= (v < vo) ^ (a < azero_i);
      end
    end
  end

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      mag_w[p] = (45'(prod_q[p]) * 45'(gain_i) + 45'd32768) >> 16;
      if (neg_q[p])
        pow_o[p] = (mag_w[p] > 45'd16777216) ? -25'sd16777216 : -$signed(25'(mag_w[p]));
      else
        pow_o[p] = (mag_w[p] > 45'd16777215) ? 25'sd16777215 : $signed(25'(mag_w[p]));
    end
    for (int c = 0; c < Channels; c++) med_o[c] = buf_q[c][HistoryLen/2];
  end
endmodule

FILE: hdl/ac_peak_median_power_monitor.sv
// channel   dir  beat payload
// s_axis    in   four raw ADC codes, one tick
// m_axis    out  four medians and two powers
// cfg       in   register write, no wait
// Each tick updates the front end's levels and peaks; a closing window with a full
// history hands the peaks to the back end, which sorts in HISTORY_LEN
// passes, multiplies and holds the result until taken.
// The front end stalls only while a handoff waits. Reset clears control.
module ac_peak_median_power_monitor #(
  parameter int unsigned HISTORY_LEN = apm_pkg::HistoryLenDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // volt_one, volt_two, amp_one, amp_two
  input  logic [((4*apm_pkg::SampleBitsDefault+7)/8)*8-1:0] s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // med v1, v2, a1, a2, power_one_mw, power_two_mw
  output logic [103:0]            m_axis_tdata,
  input  logic                    cfg_we_i,
  input  logic [apm_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [apm_pkg::CfgDataBits-1:0] cfg_data_i
);
  import apm_pkg::*;

  localparam int unsigned SAMPLE_BITS = SampleBitsDefault;

  logic [7:0] weight_q;
  logic [9:0] window_q;
  logic [11:0] voff1_q, voff2_q, azero_q;
  logic [19:0] gain_q;
  logic job_valid, job_ready;
  logic [4*HISTORY_LEN*12-1:0] job_hist;
  logic [11:0] med [4];
  logic signed [24:0] pow [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= 8'd77;
      window_q <= 10'd100;
      voff1_q  <= '0;
      voff2_q  <= '0;
      azero_q  <= 12'd3103;
      gain_q   <= 20'd41774;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WEIGHT: weight_q <= cfg_data_i[7:0];
        REG_WINDOW: window_q <= cfg_data_i[9:0];
        REG_VOFF1:  voff1_q  <= cfg_data_i[11:0];
        REG_VOFF2:  voff2_q  <= cfg_data_i[11:0];
        REG_AZERO:  azero_q  <= cfg_data_i[11:0];
        REG_GAIN:   gain_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  apm_front #(.HistoryLen(HISTORY_LEN)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_data_i(s_axis_tdata[4*SAMPLE_BITS-1:0]),
    .weight_i(weight_q), .window_i(window_q),
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_hist_o(job_hist)
  );

  apm_back #(.HistoryLen(HISTORY_LEN)) u_back (
    .clk_i, .rst_ni,
    .job_valid_i(job_valid), .job_ready_o(job_ready), .job_hist_i(job_hist),
    .voff1_i(voff1_q), .voff2_i(voff2_q), .azero_i(azero_q), .gain_i(gain_q),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .med_o(med), .pow_o(pow)
  );

  assign m_axis_tdata = {6'd0, pow[1], pow[0], med[3], med[2], med[1], med[0]};

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_job_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid && !job_ready |=> job_valid)
    else $error("handoff dropped");
endmodule

FILE: sim/ac_peak_median_power_monitor_test.sv
`timescale 1ns / 1ps

module ac_peak_median_power_monitor_test;
  import apm_pkg::*;

  localparam logic [CfgIdxBits-1:0] RegUnusedLo = 3'd6;
  localparam logic [CfgIdxBits-1:0] RegUnusedHi = 3'd7;
  localparam int unsigned HistLen = HistoryLenDefault;

  typedef struct packed {
    logic [11:0] amp_two;
    logic [11:0] amp_one;
    logic [11:0] volt_two;
    logic [11:0] volt_one;
  } tick_t;

  typedef struct packed {
    logic [24:0] pow_two;
    logic [24:0] pow_one;
    logic [11:0] med_amp_two;
    logic [11:0] med_amp_one;
    logic [11:0] med_volt_two;
    logic [11:0] med_volt_one;
  } report_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx_i = '0;
  logic [CfgDataBits-1:0] cfg_data_i = '0;

  ac_peak_median_power_monitor dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor copy of registers and state
  int unsigned weight = 77, win_limit = 100, voff_one = 0, voff_two = 0;
  int unsigned amp_zero = 3103, gain = 41774;
  int unsigned level [4];
  int unsigned peak [4];
  int unsigned ticks = 0, stored = 0;
  int unsigned history [4][HistLen];

  tick_t pending_ticks [$];
  report_t expected_reports [$];
  int errors = 0;
  int reports_seen = 0;

  function automatic int unsigned median_of_history(int ch);
    int unsigned buf_v [HistLen];
    int unsigned v;
    int b;
    for (int a = 0; a < HistLen; a++) begin
      v = history[ch][a];
      b = a;
      while (b > 0 && buf_v[b-1] > v) begin
        buf_v[b] = buf_v[b-1];
        b--;
      end
      buf_v[b] = v;
    end
    return buf_v[HistLen/2];
  endfunction

  function automatic logic [24:0] power_mw(int unsigned v, int unsigned off,
                                           int unsigned a, int unsigned z);
    longint dv, di, mag;
    bit neg;
    dv = longint'(v) - longint'(off);
    di = longint'(a) - longint'(z);
    neg = (dv < 0) ^ (di < 0);
    if (dv < 0) dv = -dv;
    if (di < 0) di = -di;
    mag = (dv * di * longint'(gain) + 32768) >>> 16;
    if (neg) begin
      if (mag > 16777216) mag = 16777216;
      mag = -mag;
    end else if (mag > 16777215) begin
      mag = 16777215;
    end
    return mag[24:0];
  endfunction

  task automatic track_tick(tick_t t);
    int unsigned x [4];
    int unsigned med [4];
    report_t r;
    x[0] = t.volt_one; x[1] = t.volt_two; x[2] = t.amp_one; x[3] = t.amp_two;
    for (int c = 0; c < 4; c++) begin
      level[c] = (weight * level[c] + (256 - weight) * (x[c] << 8) + 128) >> 8;
      if (level[c] > peak[c]) peak[c] = level[c];
    end
    if (ticks > win_limit || ticks >= 1023) begin
      if (stored < HistLen) begin
        for (int c = 0; c < 4; c++) history[c][stored] = peak[c] >> 8;
        stored++;
      end else begin
        stored = 0;
        for (int c = 0; c < 4; c++) med[c] = median_of_history(c);
        r.med_volt_one = med[0][11:0];
        r.med_volt_two = med[1][11:0];
        r.med_amp_one  = med[2][11:0];
        r.med_amp_two  = med[3][11:0];
        r.pow_one = power_mw(med[0], voff_one, med[2], amp_zero);
        r.pow_two = power_mw(med[1], voff_two, med[3], amp_zero);
        expected_reports.push_back(r);
      end
      for (int c = 0; c < 4; c++) peak[c] = 0;
      ticks = 0;
    end else begin
      ticks++;
    end
  endtask

  // driver
  tick_t cur_tick;
  int unsigned send_gap = 0;
  bit send_burst = 1'b0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) track_tick(cur_tick);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_ticks.size() > 0) begin
          cur_tick = pending_ticks.pop_front();
          s_axis_tdata <= cur_tick;
          s_axis_tvalid <= 1'b1;
          if ($urandom_range(0, 99) == 0) send_burst = !send_burst;
          send_gap = send_burst ? 0 : $urandom_range(0, 12);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int unsigned recv_gap = 0;
  int unsigned recv_hold = 0;
  bit held_once = 1'b0;
  report_t got, want;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[97:0];
        reports_seen++;
        if (expected_reports.size() == 0) begin
          $error("unexpected beat %h", got);
          errors++;
        end else begin
          want = expected_reports.pop_front();
          if (got.med_volt_one !== want.med_volt_one) begin
            $error("median_volt_one exp %0d got %0d", want.med_volt_one, got.med_volt_one);
            errors++;
          end
          if (got.med_volt_two !== want.med_volt_two) begin
            $error("median_volt_two exp %0d got %0d", want.med_volt_two, got.med_volt_two);
            errors++;
          end
          if (got.med_amp_one !== want.med_amp_one) begin
            $error("median_amp_one exp %0d got %0d", want.med_amp_one, got.med_amp_one);
            errors++;
          end
          if (got.med_amp_two !== want.med_amp_two) begin
            $error("median_amp_two exp %0d got %0d", want.med_amp_two, got.med_amp_two);
            errors++;
          end
          if (got.pow_one !== want.pow_one) begin
            $error("power_one_mw exp %0d got %0d",
                   $signed(want.pow_one), $signed(got.pow_one));
            errors++;
          end
          if (got.pow_two !== want.pow_two) begin
            $error("power_two_mw exp %0d got %0d",
                   $signed(want.pow_two), $signed(got.pow_two));
            errors++;
          end
        end
        recv_gap = send_burst ? 0 : $urandom_range(0, 12);
        if (reports_seen == 3 && !held_once) begin
          held_once = 1'b1;
          recv_hold = 400;
        end
      end
      if (recv_hold > 0) begin
        recv_hold--;
        m_axis_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [CfgIdxBits-1:0] idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[CfgDataBits-1:0];
    case (idx)
      REG_WEIGHT: weight = val & 32'hFF;
      REG_WINDOW: win_limit = val & 32'h3FF;
      REG_VOFF1:  voff_one = val & 32'hFFF;
      REG_VOFF2:  voff_two = val & 32'hFFF;
      REG_AZERO:  amp_zero = val & 32'hFFF;
      REG_GAIN:   gain = val & 32'hFFFFF;
      default: ;
    endcase
  endtask

  task automatic configure(int unsigned w, int unsigned lim, int unsigned v1,
                           int unsigned v2, int unsigned z, int unsigned g);
    while (pending_ticks.size() > 0 || s_axis_tvalid || expected_reports.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    write_reg(REG_WEIGHT, w);
    write_reg(REG_WINDOW, lim);
    write_reg(REG_VOFF1, v1);
    write_reg(REG_VOFF2, v2);
    write_reg(REG_AZERO, z);
    write_reg(REG_GAIN, g);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [11:0] pick_code();
    case ($urandom_range(0, 9))
      0: return 12'd0;
      1: return 12'hFFF;
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic queue_random(int n);
    tick_t t;
    for (int i = 0; i < n; i++) begin
      t.volt_one = pick_code();
      t.volt_two = pick_code();
      t.amp_one = pick_code();
      t.amp_two = pick_code();
      pending_ticks.push_back(t);
    end
  endtask

  initial begin
    tick_t t;
    for (int c = 0; c < 4; c++) begin
      level[c] = 0;
      peak[c] = 0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    configure(77, 1, 0, 0, 3103, 41774);
    // ignored indexes
    write_reg(RegUnusedLo, 20'hFFFFF);
    write_reg(RegUnusedHi, 20'h00001);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    for (int i = 0; i < 24; i++) begin
      case (i % 6)
        0: t = '0;
        1: t = '1;
        2: t = {4{12'hAAA}};
        3: t = {4{12'h555}};
        4: t = {12'hFFF, 12'h000, 12'hFFF, 12'h000};
        default: t = {12'h000, 12'hFFF, 12'h000, 12'hFFF};
      endcase
      pending_ticks.push_back(t);
    end

    configure(0, 0, 4095, 4095, 0, 1048575);
    queue_random(250);
    configure(255, 3, 0, 0, 4095, 0);
    queue_random(250);
    configure(0, 0, 0, 0, 4095, 1048575);
    queue_random(150);
    for (int p = 0; p < 3; p++) begin
      configure($urandom_range(0, 255), $urandom_range(1, 6), $urandom_range(0, 4095),
                $urandom_range(0, 4095), $urandom_range(0, 4095),
                $urandom_range(0, 1048575));
      queue_random(250);
    end
    configure($urandom_range(0, 255), $urandom_range(0, 20), $urandom_range(0, 2000),
              $urandom_range(0, 2000), 3103, 41774);
    queue_random(100);

    while (pending_ticks.size() > 0 || s_axis_tvalid || expected_reports.size() > 0)
      @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (errors == 0) begin
      $display("ac_peak_median_power_monitor_test: done, clean");
    end else begin
      $display("ac_peak_median_power_monitor_test: done, errors");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("ac_peak_median_power_monitor_test: done, errors");
    $finish;
  end
endmodule
